// ----- src/rld_pkg.sv -----
package rld_pkg;

    // internal fixed-point word: signed, held within +-(2^62 - 1)
    localparam int QW        = 64;
    localparam int MAG_W     = 62;
    localparam int HALF_W    = MAG_W / 2;
    localparam int OUT_W     = 32;
    localparam int COEF_W    = 32;
    localparam int NUM_COEF  = 8;
    localparam int CFG_IDX_W = 3;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 24;

    localparam logic signed [QW-1:0] LIM       = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [QW-1:0] NEG_LIM   = 64'shC000_0000_0000_0001;
    localparam logic signed [QW-1:0] OUT_MAX_Q = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [QW-1:0] OUT_MIN_Q = 64'shFFFF_FFFF_8000_0000;

    // unit latencies
    localparam int MUL_LAT = 4;
    localparam int DIV_LAT = MAG_W + 3;

    // pipeline schedule, stage at which each value is registered
    localparam int T_XP   = DIV_LAT;
    localparam int T_XX   = T_XP + MUL_LAT;
    localparam int T_R2   = T_XX + 1;
    localparam int T_TX   = T_R2 + 1;
    localparam int T_R4   = T_R2 + MUL_LAT;
    localparam int T_R6   = T_R4 + MUL_LAT;
    localparam int T_PROD = T_R6 + MUL_LAT;
    localparam int T_POLY = T_PROD + 1;
    localparam int T_XNUM = T_POLY + MUL_LAT;
    localparam int T_DIV  = T_XNUM + DIV_LAT;
    localparam int T_TAN  = T_DIV - MUL_LAT;
    localparam int T_FIN  = T_DIV + 1;

    localparam int DLY_R2_R6   = T_R4 - T_R2;
    localparam int DLY_R2_PROD = T_R6 - T_R2;
    localparam int DLY_R4_PROD = T_R6 - T_R4;
    localparam int DLY_XP      = T_POLY - T_XP;
    localparam int DLY_DEN     = T_XNUM - T_POLY;
    localparam int DLY_ZDEN    = T_FIN - T_POLY;
    localparam int DLY_XY      = T_TAN - T_XX;
    localparam int DLY_TX      = T_TAN - T_TX;
    localparam int DLY_FLAG    = T_FIN;

    typedef struct packed {
        logic                 sat;
        logic signed [QW-1:0] v;
    } qval_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SAT,
        ST_ZERO_DEPTH,
        ST_ZERO_DEN
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_K1,
        IDX_K2,
        IDX_P1,
        IDX_P2,
        IDX_K3,
        IDX_K4,
        IDX_K5,
        IDX_K6
    } coef_idx_t;

    // saturating add, flags carried along
    function automatic qval_t sadd(input qval_t a, input qval_t b);
        logic signed [QW-1:0] s;
        qval_t                r;
        s     = a.v + b.v;
        r.sat = a.sat | b.sat;
        r.v   = s;
        if (s > LIM) begin
            r.v   = LIM;
            r.sat = 1'b1;
        end else if (s < NEG_LIM) begin
            r.v   = NEG_LIM;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [QW-1:0] a);
        logic signed [QW-1:0] m;
        m = a[QW-1] ? -a : a;
        return m[MAG_W-1:0];
    endfunction

    function automatic qval_t coef_q(input logic [COEF_W-1:0] c);
        qval_t r;
        r.sat = 1'b0;
        r.v   = {{(QW-COEF_W){c[COEF_W-1]}}, c};
        return r;
    endfunction

endpackage

// ----- src/rld_delay.sv -----
module rld_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end else if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

// ----- src/rld_mul.sv -----
module rld_mul #(
    parameter int FRAC_BITS = rld_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          en,
    input  rld_pkg::qval_t a,
    input  rld_pkg::qval_t b,
    output rld_pkg::qval_t p
);

    import rld_pkg::*;

    localparam int PW = 2 * MAG_W;

    logic [MAG_W-1:0] ua_reg, ub_reg;
    logic             neg_a_reg, sat_a_reg;
    logic [MAG_W-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic             neg_b_reg, sat_b_reg;
    logic [PW-1:0]    prod_reg, prod_next;
    logic             neg_c_reg, sat_c_reg;
    qval_t            p_reg, p_next;

    // partial products are summed one stage after they are formed
    always_comb
    begin
        prod_next = (PW'(hh_reg) << MAG_W)
                  + ((PW'(lh_reg) + PW'(hl_reg)) << HALF_W)
                  + PW'(ll_reg);
    end

    // truncate toward zero, clamp the magnitude, restore the sign
    always_comb
    begin
        logic                 ovf;
        logic [MAG_W-1:0]     mq;
        logic signed [QW-1:0] mv;
        ovf = (prod_reg >> (MAG_W + FRAC_BITS)) != '0;
        mq  = ovf ? LIM[MAG_W-1:0] : prod_reg[MAG_W+FRAC_BITS-1:FRAC_BITS];
        mv  = {{(QW-MAG_W){1'b0}}, mq};
        p_next.v   = neg_c_reg ? -mv : mv;
        p_next.sat = sat_c_reg | ovf;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg    <= mag_of(a.v);
            ub_reg    <= mag_of(b.v);
            neg_a_reg <= a.v[QW-1] ^ b.v[QW-1];
            sat_a_reg <= a.sat | b.sat;

            ll_reg    <= MAG_W'(ua_reg[HALF_W-1:0]) * MAG_W'(ub_reg[HALF_W-1:0]);
            lh_reg    <= MAG_W'(ua_reg[HALF_W-1:0]) * MAG_W'(ub_reg[MAG_W-1:HALF_W]);
            hl_reg    <= MAG_W'(ua_reg[MAG_W-1:HALF_W]) * MAG_W'(ub_reg[HALF_W-1:0]);
            hh_reg    <= MAG_W'(ua_reg[MAG_W-1:HALF_W]) * MAG_W'(ub_reg[MAG_W-1:HALF_W]);
            neg_b_reg <= neg_a_reg;
            sat_b_reg <= sat_a_reg;

            prod_reg  <= prod_next;
            neg_c_reg <= neg_b_reg;
            sat_c_reg <= sat_b_reg;

            p_reg     <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- src/rld_div.sv -----
module rld_div #(
    parameter int FRAC_BITS = rld_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          en,
    input  rld_pkg::qval_t num,
    input  rld_pkg::qval_t den,
    output rld_pkg::qval_t quo
);

    import rld_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] nlow;
        logic [MAG_W-1:0] q;
        logic [MAG_W-1:0] ub;
        logic             neg;
        logic             ovf;
        logic             sat;
    } div_step_t;

    logic [MAG_W-1:0] ua_reg, ub_reg;
    logic             neg_reg, sat_reg;
    div_step_t        step_reg  [MAG_W+1];
    div_step_t        step_next [MAG_W+1];
    qval_t            quo_reg, quo_next;

    // restoring division, one quotient bit per stage
    always_comb
    begin
        logic [MAG_W:0] rem0;
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           qbit;
        // integer part too large when the top of the dividend already reaches the divisor
        rem0                = (MAG_W+1)'(ua_reg >> (MAG_W - FRAC_BITS));
        step_next[0].rem    = rem0[MAG_W-1:0];
        step_next[0].nlow   = ua_reg << FRAC_BITS;
        step_next[0].q      = '0;
        step_next[0].ub     = ub_reg;
        step_next[0].neg    = neg_reg;
        step_next[0].ovf    = rem0 >= {1'b0, ub_reg};
        step_next[0].sat    = sat_reg;
        for (int i = 0; i < MAG_W; i++)
        begin
            trial        = {step_reg[i].rem, step_reg[i].nlow[MAG_W-1]};
            diff         = trial - {1'b0, step_reg[i].ub};
            qbit         = trial >= {1'b0, step_reg[i].ub};
            step_next[i+1]      = step_reg[i];
            step_next[i+1].rem  = qbit ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            step_next[i+1].nlow = step_reg[i].nlow << 1;
            step_next[i+1].q    = {step_reg[i].q[MAG_W-2:0], qbit};
        end
    end

    always_comb
    begin
        logic [MAG_W-1:0]     mq;
        logic signed [QW-1:0] mv;
        mq = step_reg[MAG_W].ovf ? LIM[MAG_W-1:0] : step_reg[MAG_W].q;
        mv = {{(QW-MAG_W){1'b0}}, mq};
        quo_next.v   = step_reg[MAG_W].neg ? -mv : mv;
        quo_next.sat = step_reg[MAG_W].sat | step_reg[MAG_W].ovf;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg  <= mag_of(num.v);
            ub_reg  <= mag_of(den.v);
            neg_reg <= num.v[QW-1] ^ den.v[QW-1];
            sat_reg <= num.sat | den.sat;
            for (int i = 0; i <= MAG_W; i++)
            begin
                step_reg[i] <= step_next[i];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ----- src/rational_lens_distortion.sv -----
// rational lens distortion, eight coefficients (k1..k6 radial, p1 p2 tangential)
// slave stream: one camera-frame point per transfer (x, y, z, one common scale);
// master stream: distorted normalised x and y in signed Q8.24 and a status code
// (ok, saturated, zero depth, zero rational denominator) on tuser
// coefficients are written through cfg_we / cfg_index / cfg_data while no point is
// in flight; reset clears every coefficient to zero
// throughput: one point per cycle while the receiver does not stall, every stage advances together
// path from the input transfer to the result on the master side: the two 65-stage
// dividers (x/z and y/z, then the rational quotient), five 4-stage multiplier
// passes and four single-stage sums in between
// when the receiver stalls, the whole pipeline and its output register hold and
// s_tready falls; nothing is dropped or repeated, and s_tready stays high while
// the output register is empty or being taken
// reset empties the pipeline (all valid bits cleared), m_tvalid low
// the result register parts the two sides, so s_tready never waits on a pipeline
// state, only on the receiver
module rational_lens_distortion #(
    parameter int COORD_WIDTH = rld_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rld_pkg::FRAC_BITS_DEF,
    localparam int IN_TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [rld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rld_pkg::COEF_W-1:0]    cfg_data,
    // input points
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_TDATA_W-1:0]         s_tdata,  // point_x, point_y, point_z, zero pad
    // distorted points
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*rld_pkg::OUT_W-1:0]   m_tdata,  // distorted_x, distorted_y
    output logic [1:0]                    m_tuser   // status
);

    import rld_pkg::*;

    localparam int QVW = $bits(qval_t);

    // pipeline advance: output register empty or being taken
    logic en;
    logic in_acc;

    logic [COEF_W-1:0] coef_reg [NUM_COEF];

    logic [COORD_WIDTH-1:0] cx, cy, cz;
    qval_t x_q, y_q, z_q;
    logic  z_zero;

    qval_t xp, yp, xx, yy, xy;
    qval_t r2_reg, r2_next, xx2_reg, xx2_next, yy2_reg, yy2_next;
    qval_t tx_reg, tx_next, ty_reg, ty_next;
    qval_t r4, r6, r2_d6, r2_dp, r4_dp;
    qval_t k1r2, k2r4, k3r6, k4r2, k5r4, k6r6;
    qval_t num_reg, num_next, den_reg, den_next;
    qval_t xp_d, yp_d, xnum, ynum, den_d, dvx, dvy;
    qval_t xy_d, tx_d, ty_d;
    qval_t tp1xy, tp2tx, tp1ty, tp2xy;
    qval_t xa_reg, xa_next, xb_reg, ya_reg, ya_next, yb_reg, yb_next;
    qval_t one_q;
    logic  den_zero, zden_end, zd_end, vld_end;

    qval_t           fx, fy;
    logic            fx_sat, fy_sat;
    logic [OUT_W-1:0] ox, oy;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    status_t          status_reg, status_next;

    assign en     = !out_valid_reg || m_tready;
    assign in_acc = s_tvalid && en;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // unpack and sign-extend the point
    assign cx = s_tdata[COORD_WIDTH-1:0];
    assign cy = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign cz = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

    assign x_q    = '{sat: 1'b0, v: {{(QW-COORD_WIDTH){cx[COORD_WIDTH-1]}}, cx}};
    assign y_q    = '{sat: 1'b0, v: {{(QW-COORD_WIDTH){cy[COORD_WIDTH-1]}}, cy}};
    assign z_q    = '{sat: 1'b0, v: {{(QW-COORD_WIDTH){cz[COORD_WIDTH-1]}}, cz}};
    assign z_zero = cz == '0;

    assign one_q  = '{sat: 1'b0, v: QW'(1) << FRAC_BITS};

    // valid bits and per-point flags travel alongside the data
    rld_delay #(.WIDTH(1), .DEPTH(DLY_FLAG)) u_vld (
        .clk(clk), .rst_n(rst_n), .en(en), .d(in_acc), .q(vld_end)
    );
    rld_delay #(.WIDTH(1), .DEPTH(DLY_FLAG)) u_zd (
        .clk(clk), .rst_n(rst_n), .en(en), .d(z_zero), .q(zd_end)
    );

    // normalised coordinates
    rld_div #(.FRAC_BITS(FRAC_BITS)) u_div_xp (
        .clk(clk), .en(en), .num(x_q), .den(z_q), .quo(xp)
    );
    rld_div #(.FRAC_BITS(FRAC_BITS)) u_div_yp (
        .clk(clk), .en(en), .num(y_q), .den(z_q), .quo(yp)
    );

    // squares and cross term
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xx (.clk(clk), .en(en), .a(xp), .b(xp), .p(xx));
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_yy (.clk(clk), .en(en), .a(yp), .b(yp), .p(yy));
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xy (.clk(clk), .en(en), .a(xp), .b(yp), .p(xy));

    // r^2 and the doubled squares for the tangential part
    always_comb
    begin
        r2_next  = sadd(xx, yy);
        xx2_next = sadd(xx, xx);
        yy2_next = sadd(yy, yy);
        tx_next  = sadd(r2_reg, xx2_reg);
        ty_next  = sadd(r2_reg, yy2_reg);
    end

    // r^4, r^6
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_r4 (
        .clk(clk), .en(en), .a(r2_reg), .b(r2_reg), .p(r4)
    );
    rld_delay #(.WIDTH(QVW), .DEPTH(DLY_R2_R6)) u_d_r2a (
        .clk(clk), .rst_n(rst_n), .en(en), .d(r2_reg), .q(r2_d6)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_r6 (
        .clk(clk), .en(en), .a(r4), .b(r2_d6), .p(r6)
    );
    rld_delay #(.WIDTH(QVW), .DEPTH(DLY_R2_PROD)) u_d_r2b (
        .clk(clk), .rst_n(rst_n), .en(en), .d(r2_reg), .q(r2_dp)
    );
    rld_delay #(.WIDTH(QVW), .DEPTH(DLY_R4_PROD)) u_d_r4 (
        .clk(clk), .rst_n(rst_n), .en(en), .d(r4), .q(r4_dp)
    );

    // polynomial terms of numerator and denominator, all at one stage
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k1 (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_K1])), .b(r2_dp), .p(k1r2)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k2 (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_K2])), .b(r4_dp), .p(k2r4)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k3 (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_K3])), .b(r6), .p(k3r6)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k4 (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_K4])), .b(r2_dp), .p(k4r2)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k5 (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_K5])), .b(r4_dp), .p(k5r4)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k6 (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_K6])), .b(r6), .p(k6r6)
    );

    // sums in the order 1 + c1 r2 + c2 r4 + c3 r6, each step saturating
    always_comb
    begin
        num_next = sadd(sadd(sadd(one_q, k1r2), k2r4), k3r6);
        den_next = sadd(sadd(sadd(one_q, k4r2), k5r4), k6r6);
    end

    assign den_zero = den_reg.v == '0;

    rld_delay #(.WIDTH(1), .DEPTH(DLY_ZDEN)) u_d_zden (
        .clk(clk), .rst_n(rst_n), .en(en), .d(den_zero), .q(zden_end)
    );

    // radial term: (xp * num) / den
    rld_delay #(.WIDTH(QVW), .DEPTH(DLY_XP)) u_d_xp (
        .clk(clk), .rst_n(rst_n), .en(en), .d(xp), .q(xp_d)
    );
    rld_delay #(.WIDTH(QVW), .DEPTH(DLY_XP)) u_d_yp (
        .clk(clk), .rst_n(rst_n), .en(en), .d(yp), .q(yp_d)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xn (
        .clk(clk), .en(en), .a(xp_d), .b(num_reg), .p(xnum)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_yn (
        .clk(clk), .en(en), .a(yp_d), .b(num_reg), .p(ynum)
    );
    rld_delay #(.WIDTH(QVW), .DEPTH(DLY_DEN)) u_d_den (
        .clk(clk), .rst_n(rst_n), .en(en), .d(den_reg), .q(den_d)
    );
    rld_div #(.FRAC_BITS(FRAC_BITS)) u_div_rx (
        .clk(clk), .en(en), .num(xnum), .den(den_d), .quo(dvx)
    );
    rld_div #(.FRAC_BITS(FRAC_BITS)) u_div_ry (
        .clk(clk), .en(en), .num(ynum), .den(den_d), .quo(dvy)
    );

    // tangential products, timed to land with the radial quotients
    rld_delay #(.WIDTH(QVW), .DEPTH(DLY_XY)) u_d_xy (
        .clk(clk), .rst_n(rst_n), .en(en), .d(xy), .q(xy_d)
    );
    rld_delay #(.WIDTH(QVW), .DEPTH(DLY_TX)) u_d_tx (
        .clk(clk), .rst_n(rst_n), .en(en), .d(tx_reg), .q(tx_d)
    );
    rld_delay #(.WIDTH(QVW), .DEPTH(DLY_TX)) u_d_ty (
        .clk(clk), .rst_n(rst_n), .en(en), .d(ty_reg), .q(ty_d)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p1xy (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_P1])), .b(xy_d), .p(tp1xy)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p2tx (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_P2])), .b(tx_d), .p(tp2tx)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p1ty (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_P1])), .b(ty_d), .p(tp1ty)
    );
    rld_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p2xy (
        .clk(clk), .en(en), .a(coef_q(coef_reg[IDX_P2])), .b(xy_d), .p(tp2xy)
    );

    // final sums, split over two stages in the order of evaluation
    always_comb
    begin
        xa_next = sadd(dvx, sadd(tp1xy, tp1xy));
        ya_next = sadd(dvy, tp1ty);
        yb_next = sadd(tp2xy, tp2xy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg  <= r2_next;
            xx2_reg <= xx2_next;
            yy2_reg <= yy2_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            num_reg <= num_next;
            den_reg <= den_next;
            xa_reg  <= xa_next;
            xb_reg  <= tp2tx;
            ya_reg  <= ya_next;
            yb_reg  <= yb_next;
        end
    end

    // clamp to the 32-bit output range and pick the status
    always_comb
    begin
        fx     = sadd(xa_reg, xb_reg);
        fy     = sadd(ya_reg, yb_reg);
        fx_sat = 1'b0;
        fy_sat = 1'b0;
        ox     = fx.v[OUT_W-1:0];
        oy     = fy.v[OUT_W-1:0];
        if (fx.v > OUT_MAX_Q)
        begin
            ox     = OUT_MAX_Q[OUT_W-1:0];
            fx_sat = 1'b1;
        end else if (fx.v < OUT_MIN_Q)
        begin
            ox     = OUT_MIN_Q[OUT_W-1:0];
            fx_sat = 1'b1;
        end
        if (fy.v > OUT_MAX_Q)
        begin
            oy     = OUT_MAX_Q[OUT_W-1:0];
            fy_sat = 1'b1;
        end else if (fy.v < OUT_MIN_Q)
        begin
            oy     = OUT_MIN_Q[OUT_W-1:0];
            fy_sat = 1'b1;
        end

        out_x_next  = ox;
        out_y_next  = oy;
        status_next = (fx.sat || fy.sat || fx_sat || fy_sat) ? ST_SAT : ST_OK;
        if (zd_end)
        begin
            // zero depth wins over everything else
            out_x_next  = '0;
            out_y_next  = '0;
            status_next = ST_ZERO_DEPTH;
        end else if (zden_end)
        begin
            out_x_next  = '0;
            out_y_next  = '0;
            status_next = ST_ZERO_DEN;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (en)
        begin
            out_valid_reg <= vld_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            status_reg <= status_next;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = status_reg;

endmodule
